[sv/mwo_pkg.sv]
// Package for the multi-waveform oscillator: widths, register codes, shared types
// and the quarter-wave sine table. Has no dependencies; every module imports it.
`default_nettype none

package mwo_pkg;

  // Fixed widths of the datapath.
  localparam int PHASE_BITS       = 32;
  localparam int STEP_BITS        = 32;
  localparam int LEVEL_BITS       = 16;
  localparam int SAMPLE_BITS      = 16;
  localparam int SINE_TABLE_DEPTH = 256;
  localparam int SINE_IDX_BITS    = $clog2(SINE_TABLE_DEPTH);
  localparam int FRAC_BITS        = 16;
  localparam int WAVE_BITS        = 17;
  localparam int PROD1_BITS       = WAVE_BITS + LEVEL_BITS;
  localparam int PROD_BITS        = PROD1_BITS + LEVEL_BITS + 1;
  localparam int OUT_SHIFT        = 31 - SAMPLE_BITS;
  localparam int SUM_BITS         = ((PHASE_BITS > STEP_BITS) ? PHASE_BITS : STEP_BITS) + 1;
  localparam int SAT_BITS         = PROD_BITS - OUT_SHIFT;

  // Small queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration port.
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_WAVE_MODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PHASE_STEP = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN       = 2'd2;

  localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET = 32'd39370534;
  localparam logic [LEVEL_BITS-1:0] GAIN_RESET       = 16'd32768;

  // Half pi in Q30, used to build the table.
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SAW      = 2'd1,
    WAVE_SQUARE   = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_mode_t;

  typedef struct packed {
    wave_mode_t             wave_mode;
    logic [STEP_BITS-1:0]   phase_step;
    logic [LEVEL_BITS-1:0]  gain;
  } cfg_t;

  // One word held in the queue: the updated phase and the tick's side data.
  typedef struct packed {
    logic [PHASE_BITS-1:0]  phase;
    logic [LEVEL_BITS-1:0]  env;
    logic                   last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_GAIN,
    BK_ENV,
    BK_ROUND
  } back_state_t;

  // One table entry: sine by an integer Taylor series in Q30, rounded to Q15.
  function automatic logic [15:0] sine_entry(input int k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [64:0] sum;
    logic [63:0]        rnd;
    x    = (PI_HALF_Q30 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed({1'b0, x});
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd110; sum = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd156; sum = sum + $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd210; sum = sum - $signed({1'b0, term});
    term = ((term * x2) >> 30) / 64'd272; sum = sum + $signed({1'b0, term});
    if (sum < 0) begin
      sum = '0;
    end
    rnd = sum[63:0] + 64'd16384;
    return rnd[30:15];
  endfunction

  typedef logic [15:0] sine_rom_t [SINE_TABLE_DEPTH];

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
      rom[k] = sine_entry(k);
    end
    return rom;
  endfunction

  // Entries 0 to depth-1 live in the table; the quarter-wave peak stands apart.
  localparam sine_rom_t   SINE_ROM  = build_sine_rom();
  localparam logic [15:0] SINE_PEAK = sine_entry(SINE_TABLE_DEPTH);

endpackage

`default_nettype wire

[sv/multi_waveform_oscillator_core.sv]
// Top level of the multi-waveform oscillator: configuration registers and the
// front, queue and back. Depends on mwo_pkg, mwo_front, mwo_queue and mwo_back.
//
//   channel  direction  handshake          payload
//   in_      sink       in_valid/in_stall  in_envelope_level, in_frame_end
//   out_     source     out_valid/out_stall out_sample_value, out_block_last
//   cfg_     sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// Each word passes through the back sequencer's steps in order (wave lookup, gain product,
// envelope product, rounding); the back takes a new word only once the last is done.
// The front advances the phase on acceptance and can run up to two words ahead.
// Reset is synchronous and active low; it clears the phase, queue and registers.
// A stalled output holds its word while the back finishes the next one.
`default_nettype none

module multi_waveform_oscillator_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [mwo_pkg::LEVEL_BITS-1:0]       in_envelope_level,
  input  wire logic                                 in_frame_end,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [mwo_pkg::SAMPLE_BITS-1:0]    out_sample_value,
  output logic                                      out_block_last,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [mwo_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  wire logic [mwo_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import mwo_pkg::*;

  cfg_t      cfg_r;
  cfg_t      cfg_nxt;
  q_status_t q_stat;
  q_entry_t  push_data;
  q_entry_t  head;
  logic      push;
  logic      pop;

  // Register writes are always taken; an unknown index is dropped.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_WAVE_MODE:  cfg_nxt.wave_mode  = wave_mode_t'(cfg_data[1:0]);
        CFG_PHASE_STEP: cfg_nxt.phase_step = cfg_data[STEP_BITS-1:0];
        CFG_GAIN:       cfg_nxt.gain       = cfg_data[LEVEL_BITS-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_mode  <= WAVE_SINE;
      cfg_r.phase_step <= PHASE_STEP_RESET;
      cfg_r.gain       <= GAIN_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mwo_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_envelope_level (in_envelope_level),
    .in_frame_end      (in_frame_end),
    .cfg               (cfg_r),
    .q_stat            (q_stat),
    .push              (push),
    .push_data         (push_data)
  );

  mwo_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  mwo_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample_value (out_sample_value),
    .out_block_last   (out_block_last)
  );

  // Reset leaves no result word pending.
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A phase step write lands in the register in the next cycle.
  a_step_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && cfg_index == CFG_PHASE_STEP)
      |=> (cfg_r.phase_step == $past(cfg_data)))
    else $error("phase step write lost");

  // An empty queue never holds off the source.
  a_empty_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !in_stall)
    else $error("input stalled with empty queue");

  // The back never pops an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

[sv/mwo_front.sv]
// Front of the oscillator: accepts tick words and advances the phase accumulator.
// Depends on mwo_pkg; feeds mwo_queue.
`default_nettype none

module mwo_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mwo_pkg::LEVEL_BITS-1:0] in_envelope_level,
  input  wire logic                          in_frame_end,
  input  wire mwo_pkg::cfg_t                 cfg,
  input  wire mwo_pkg::q_status_t            q_stat,
  output logic                               push,
  output mwo_pkg::q_entry_t                  push_data
);
  import mwo_pkg::*;

  logic [PHASE_BITS-1:0] phase_r;
  logic [PHASE_BITS-1:0] phase_nxt;
  logic [SUM_BITS-1:0]   sum;
  logic                  overflow;
  logic [PHASE_BITS-1:0] phase_new;

  // A word is taken whenever the queue has room.
  assign in_stall = q_stat.full;
  assign push     = in_valid && !in_stall;

  // Sine wraps around the cycle; the other waves restart at zero on overflow.
  always_comb begin
    sum       = SUM_BITS'(phase_r) + SUM_BITS'(cfg.phase_step);
    overflow  = |sum[SUM_BITS-1:PHASE_BITS];
    phase_new = sum[PHASE_BITS-1:0];
    if (cfg.wave_mode != WAVE_SINE && overflow) begin
      phase_new = '0;
    end
    phase_nxt = push ? phase_new : phase_r;
  end

  assign push_data.phase = phase_new;
  assign push_data.env   = in_envelope_level;
  assign push_data.last  = in_frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/mwo_queue.sv]
// Short first-in first-out queue of phase words between front and back.
// Depends on mwo_pkg.
`default_nettype none

module mwo_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire mwo_pkg::q_entry_t  push_data,
  input  wire logic               pop,
  output mwo_pkg::q_entry_t       head,
  output mwo_pkg::q_status_t      q_stat
);
  import mwo_pkg::*;

  q_entry_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_r;
  logic [QPTR_BITS-1:0] wr_ptr_nxt;
  logic [QPTR_BITS-1:0] rd_ptr_r;
  logic [QPTR_BITS-1:0] rd_ptr_nxt;
  logic [QCNT_BITS-1:0] count_r;
  logic [QCNT_BITS-1:0] count_nxt;

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (count_r == QCNT_BITS'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[sv/mwo_back.sv]
// Back of the oscillator: wave lookup, gain and envelope products, rounding and
// saturation, and the output register. Depends on mwo_pkg; reads mwo_queue.
`default_nettype none

module mwo_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire mwo_pkg::cfg_t                        cfg,
  input  wire mwo_pkg::q_status_t                   q_stat,
  input  wire mwo_pkg::q_entry_t                    head,
  output logic                                      pop,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [mwo_pkg::SAMPLE_BITS-1:0]    out_sample_value,
  output logic                                      out_block_last
);
  import mwo_pkg::*;

  localparam logic signed [SAT_BITS-1:0] SAT_HI = SAT_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SAT_BITS-1:0] SAT_LO = -SAT_BITS'(1 << (SAMPLE_BITS - 1));
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1 << (OUT_SHIFT - 1));

  back_state_t                    state_r;
  back_state_t                    state_nxt;
  logic signed [WAVE_BITS-1:0]    w_r;
  logic signed [WAVE_BITS-1:0]    w_nxt;
  logic signed [PROD1_BITS-1:0]   m1_r;
  logic signed [PROD_BITS-1:0]    m2_r;
  logic [LEVEL_BITS-1:0]          env_r;
  logic                           last_r;
  logic                           out_valid_r;
  logic                           out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0]  sample_r;
  logic                           block_last_r;
  logic                           out_free;
  logic                           load_m1;
  logic                           load_m2;
  logic                           load_out;
  logic signed [PROD_BITS-1:0]    rounded;
  logic signed [SAT_BITS-1:0]     scaled;
  logic signed [SAMPLE_BITS-1:0]  sat_value;

  // Wave value from the phase at the queue head.
  always_comb begin
    logic [FRAC_BITS-1:0]     f;
    logic [1:0]               quad;
    logic [SINE_IDX_BITS-1:0] idx;
    logic [15:0]              mag;
    logic signed [WAVE_BITS:0] tri_val;
    f    = head.phase[PHASE_BITS-1 -: FRAC_BITS];
    quad = head.phase[PHASE_BITS-1 -: 2];
    idx  = head.phase[PHASE_BITS-3 -: SINE_IDX_BITS];
    // Falling quadrants read the table mirrored; a zero index there is the peak.
    if (quad[0]) begin
      mag = (idx == '0) ? SINE_PEAK : SINE_ROM[SINE_IDX_BITS'(-idx)];
    end else begin
      mag = SINE_ROM[idx];
    end
    tri_val = f[FRAC_BITS-1] ? ((WAVE_BITS+1)'(98304) - $signed({1'b0, f, 1'b0}))
                             : ($signed({1'b0, f, 1'b0}) - (WAVE_BITS+1)'(32768));
    case (cfg.wave_mode)
      WAVE_SINE:     w_nxt = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      WAVE_SAW:      w_nxt = $signed({1'b0, f}) - WAVE_BITS'(32768);
      WAVE_SQUARE:   w_nxt = f[FRAC_BITS-1] ? WAVE_BITS'(32768) : -WAVE_BITS'(32768);
      default:       w_nxt = tri_val[WAVE_BITS-1:0];
    endcase
  end

  // Round to nearest with ties upwards, then clamp to the sample range.
  always_comb begin
    rounded = m2_r + ROUND_HALF;
    scaled  = rounded[PROD_BITS-1:OUT_SHIFT];
    if (scaled > SAT_HI) begin
      sat_value = SAT_HI[SAMPLE_BITS-1:0];
    end else if (scaled < SAT_LO) begin
      sat_value = SAT_LO[SAMPLE_BITS-1:0];
    end else begin
      sat_value = scaled[SAMPLE_BITS-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE:  if (!q_stat.empty) state_nxt = BK_GAIN;
      BK_GAIN:  state_nxt = BK_ENV;
      BK_ENV:   state_nxt = BK_ROUND;
      BK_ROUND: if (out_free) state_nxt = BK_IDLE;
      default:  state_nxt = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pop      = 1'b0;
    load_m1  = 1'b0;
    load_m2  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      BK_IDLE:  pop      = !q_stat.empty;
      BK_GAIN:  load_m1  = 1'b1;
      BK_ENV:   load_m2  = 1'b1;
      BK_ROUND: load_out = out_free;
      default:  pop      = 1'b0;
    endcase
  end

  // The output register holds its word until the sink takes it.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, one product per stage.
  always_ff @(posedge clk) begin
    if (pop) begin
      w_r    <= w_nxt;
      env_r  <= head.env;
      last_r <= head.last;
    end
    if (load_m1) begin
      m1_r <= PROD1_BITS'(w_r * $signed({1'b0, cfg.gain}));
    end
    if (load_m2) begin
      m2_r <= PROD_BITS'(m1_r * $signed({1'b0, env_r}));
    end
    if (load_out) begin
      sample_r     <= sat_value;
      block_last_r <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sample_value = sample_r;
  assign out_block_last   = block_last_r;

endmodule

`default_nettype wire

[tb/multi_waveform_oscillator_core_tb.sv]
// Self-checking testbench for multi_waveform_oscillator_core: directed ticks, then random
// phases of register settings and ticks, checked word by word against a local predictor.
// Depends on mwo_pkg for widths, register indexes and the wave mode codes.
`timescale 1ns / 100ps

module multi_waveform_oscillator_core_tb;
  import mwo_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;
  localparam int PHASE_COUNT = 24;
  localparam int TICKS_PER_PHASE = 48;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_ZERO = 16'sh0000;

  // One expected output word.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } tick_result_t;

  // One row of the directed table: an optional register write, then one tick.
  typedef struct packed {
    logic                          set_reg;
    logic [CFG_INDEX_BITS-1:0]     reg_sel;
    logic [CFG_DATA_BITS-1:0]      reg_word;
    logic [LEVEL_BITS-1:0]         level;
    logic                          last;
    logic                          fixed;
    logic signed [SAMPLE_BITS-1:0] fixed_value;
  } tick_row_t;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [LEVEL_BITS-1:0] in_envelope_level = '0;
  logic in_frame_end = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample_value;
  logic out_block_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state: registers and phase as the block should hold them.
  wave_mode_t tone_mode = WAVE_SINE;
  logic [STEP_BITS-1:0] tone_step = PHASE_STEP_RESET;
  logic [LEVEL_BITS-1:0] tone_gain = GAIN_RESET;
  logic [PHASE_BITS-1:0] tone_phase = '0;
  int unsigned quarter_sine [0:SINE_TABLE_DEPTH];

  tick_result_t samples_due [$];
  bit steady = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned sample_count = 0;
  int unsigned reg_write_count = 0;

  tick_row_t directed_ticks [23] = '{
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd0, 1'b0, 1'b1, SAMPLE_ZERO},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd32768, 1'b1, 1'b1, SAMPLE_MAX},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd1, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'hFFFF, 1'b0, 1'b1, SAMPLE_MAX},
    '{1'b1, CFG_GAIN, 32'hFFFF_0000, 16'hFFFF, 1'b0, 1'b1, SAMPLE_ZERO},
    '{1'b1, CFG_GAIN, 32'h0000_FFFF, 16'd1, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_WAVE_MODE, {30'h3FFF_FFFF, WAVE_SQUARE}, 16'd32768, 1'b0, 1'b1, SAMPLE_MIN},
    '{1'b1, CFG_PHASE_STEP, 32'h8000_0000, 16'd32768, 1'b0, 1'b1, SAMPLE_MAX},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd1, 1'b0, 1'b1, SAMPLE_MIN},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd1, 1'b1, 1'b1, SAMPLE_MAX},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd1, 1'b0, 1'b1, SAMPLE_MIN},
    '{1'b1, CFG_PHASE_STEP, 32'hFFFF_FFFF, 16'd1, 1'b0, 1'b1, SAMPLE_MAX},
    '{1'b1, CFG_WAVE_MODE, {30'd0, WAVE_SINE}, 16'd1, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_GAIN, 32'h0000_8000, 16'd32768, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_PHASE_STEP, 32'h4000_0000, 16'd1, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_PHASE_STEP, 32'h0000_0003, 16'd1, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_WAVE_MODE, {30'd0, WAVE_SAW}, 16'd2, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_UNMAPPED, 32'h0000_0002, 16'd3, 1'b1, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_WAVE_MODE, {30'd0, WAVE_TRIANGLE}, 16'd4, 1'b0, 1'b0, SAMPLE_ZERO},
    '{1'b1, CFG_PHASE_STEP, 32'hC000_0000, 16'd1, 1'b0, 1'b1, SAMPLE_MIN},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'hFFFF, 1'b0, 1'b1, SAMPLE_ZERO},
    '{1'b0, CFG_WAVE_MODE, 32'd0, 16'd0, 1'b1, 1'b1, SAMPLE_ZERO},
    '{1'b1, CFG_WAVE_MODE, {30'd0, WAVE_SINE}, 16'd32768, 1'b1, 1'b0, SAMPLE_ZERO}
  };

  multi_waveform_oscillator_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_envelope_level (in_envelope_level),
    .in_frame_end      (in_frame_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_sample_value  (out_sample_value),
    .out_block_last    (out_block_last),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Quarter-wave sine entry: Taylor series in Q30 on a scaled angle, rounded to Q15.
  function automatic int unsigned sine_q15(input int unsigned k);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint total;
    angle = (64'd1686629713 * k) / SINE_TABLE_DEPTH;
    angle_sq = (angle * angle) >> 30;
    term = angle;
    total = longint'(angle);
    for (int n = 1; n <= 8; n++) begin
      term = ((term * angle_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        total = total - longint'(term);
      end else begin
        total = total + longint'(term);
      end
    end
    if (total < 0) begin
      total = 0;
    end
    return int'((total + 16384) >> 15);
  endfunction

  // Advances the phase by one tick and returns the sample the block should produce.
  function automatic logic signed [SAMPLE_BITS-1:0] oscillator_sample(
    input logic [LEVEL_BITS-1:0] level
  );
    logic [PHASE_BITS:0] phase_sum;
    logic [15:0] coarse;
    int unsigned lut_idx;
    longint wave;
    longint product;
    longint rounded;
    phase_sum = {1'b0, tone_phase} + {1'b0, tone_step};
    // Sine wraps; the other shapes restart from zero once a full cycle is reached.
    if (tone_mode == WAVE_SINE || !phase_sum[PHASE_BITS]) begin
      tone_phase = phase_sum[PHASE_BITS-1:0];
    end else begin
      tone_phase = '0;
    end
    coarse = tone_phase[PHASE_BITS-1 -: 16];
    case (tone_mode)
      WAVE_SINE: begin
        lut_idx = tone_phase[PHASE_BITS-3 -: SINE_IDX_BITS];
        if (tone_phase[PHASE_BITS-2]) begin
          lut_idx = SINE_TABLE_DEPTH - lut_idx;
        end
        wave = longint'(quarter_sine[lut_idx]);
        if (tone_phase[PHASE_BITS-1]) begin
          wave = -wave;
        end
      end
      WAVE_SAW: wave = longint'(coarse) - 32768;
      WAVE_SQUARE: wave = tone_phase[PHASE_BITS-1] ? 32768 : -32768;
      default: begin
        if (coarse[15]) begin
          wave = 98304 - 2 * longint'(coarse);
        end else begin
          wave = 2 * longint'(coarse) - 32768;
        end
      end
    endcase
    // Round to nearest with ties upwards, then clamp to the sample range.
    product = wave * longint'(tone_gain) * longint'(level);
    rounded = (product + (longint'(1) << (OUT_SHIFT - 1))) >>> OUT_SHIFT;
    if (rounded > longint'(SAMPLE_MAX)) begin
      rounded = longint'(SAMPLE_MAX);
    end else if (rounded < longint'(SAMPLE_MIN)) begin
      rounded = longint'(SAMPLE_MIN);
    end
    return rounded[SAMPLE_BITS-1:0];
  endfunction

  // Offers one tick, with random idle cycles first, and records its expected word.
  task automatic send_tick(input logic [LEVEL_BITS-1:0] level, input logic last,
                           input logic fixed, input logic signed [SAMPLE_BITS-1:0] fixed_value);
    tick_result_t due;
    while (!steady && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_envelope_level <= level;
    in_frame_end <= last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    due.sample = oscillator_sample(level);
    if (fixed) begin
      due.sample = fixed_value;
    end
    due.last = last;
    samples_due.push_back(due);
  endtask

  // Stops the sender and waits until every expected word has come out.
  task automatic drain_samples();
    in_valid <= 1'b0;
    while (samples_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // Writes one register through the configuration port and mirrors it in the predictor.
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] sel,
                           input logic [CFG_DATA_BITS-1:0] word);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= word;
    @(posedge clk);
    while (!cfg_ready) begin
      @(posedge clk);
    end
    case (sel)
      CFG_WAVE_MODE: tone_mode = wave_mode_t'(word[1:0]);
      CFG_PHASE_STEP: tone_step = word[STEP_BITS-1:0];
      CFG_GAIN: tone_gain = word[LEVEL_BITS-1:0];
      default: ;
    endcase
    reg_write_count++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side: random stall, quiet during the steady stretch.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 22);
  end

  // Compares each output word with the oldest expectation.
  always @(posedge clk) begin
    tick_result_t due;
    if (rst_n && out_valid && !out_stall) begin
      sample_count++;
      if (samples_due.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT) begin
          $display("word %0d: unexpected sample %0d, last %0b", sample_count,
                   out_sample_value, out_block_last);
        end
        mismatch_count++;
      end else begin
        due = samples_due.pop_front();
        if (out_sample_value !== due.sample || out_block_last !== due.last) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("word %0d: expected sample %0d last %0b, got sample %0d last %0b",
                     sample_count, due.sample, due.last, out_sample_value, out_block_last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d words outstanding", cycle_count,
               samples_due.size());
      $display("multi_waveform_oscillator_core regression: fail");
      $finish;
    end
  end

  initial begin
    logic [STEP_BITS-1:0] step_word;
    logic [LEVEL_BITS-1:0] gain_word;
    logic [LEVEL_BITS-1:0] level;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      quarter_sine[k] = sine_q15(k);
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: reset values, extremes, overflow, wrap and every wave shape.
    foreach (directed_ticks[r]) begin
      if (directed_ticks[r].set_reg) begin
        drain_samples();
        write_reg(directed_ticks[r].reg_sel, directed_ticks[r].reg_word);
      end
      send_tick(directed_ticks[r].level, directed_ticks[r].last, directed_ticks[r].fixed,
                directed_ticks[r].fixed_value);
    end

    // Random part: each phase settles the block, picks new registers, then streams ticks.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain_samples();
      steady = (ph >= 10 && ph < 14);
      case ($urandom_range(5))
        0: step_word = '0;
        1: step_word = '1;
        2: step_word = 32'h8000_0000;
        3: step_word = $urandom_range(32'h00FF_FFFF);
        default: step_word = $urandom();
      endcase
      case ($urandom_range(6))
        0: gain_word = '0;
        1: gain_word = '1;
        2: gain_word = GAIN_RESET;
        3: gain_word = $urandom_range(16'hFFFF);
        default: gain_word = $urandom_range(127);
      endcase
      if (ph == 0) begin
        step_word = '0;
      end
      write_reg(CFG_WAVE_MODE, $urandom());
      write_reg(CFG_PHASE_STEP, step_word);
      write_reg(CFG_GAIN, {16'($urandom()), gain_word});
      if ($urandom_range(3) == 0) begin
        write_reg(CFG_UNMAPPED, $urandom());
      end
      for (int i = 0; i < TICKS_PER_PHASE; i++) begin
        case ($urandom_range(9))
          0: level = '0;
          1: level = '1;
          2: level = 16'd32768;
          3: level = $urandom_range(16'hFFFF);
          default: level = $urandom_range(255);
        endcase
        send_tick(level, $urandom_range(7) == 0, 1'b0, SAMPLE_ZERO);
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // Let the last words come out, then keep watching for anything stray.
    while (samples_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (32) @(posedge clk);

    $display("Checked %0d output words over %0d register writes in %0d cycles,", sample_count,
             reg_write_count, cycle_count);
    $display("covering all four wave shapes, phase wrap and overflow, and saturation.");
    if (mismatch_count == 0 && samples_due.size() == 0) begin
      $display("multi_waveform_oscillator_core regression: pass");
    end else begin
      $display("%0d mismatches, %0d words never seen", mismatch_count, samples_due.size());
      $display("multi_waveform_oscillator_core regression: fail");
    end
    $finish;
  end

endmodule
